// File: rtl/cdiv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cdiv_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_STEPS = 64;
	localparam logic [4:0] RADIX_RESET = 5'd24;
	localparam logic [0:0] REG_RADIX = 1'b0;

	typedef struct packed {
		logic signed [31:0] dividend_real;
		logic signed [31:0] dividend_imag;
		logic signed [31:0] divisor_real;
		logic signed [31:0] divisor_imag;
	} op_t;

	typedef struct packed {
		logic signed [31:0] quotient_real;
		logic signed [31:0] quotient_imag;
		logic divide_by_zero;
		logic quotient_overflow;
	} res_t;

	typedef struct packed {
		logic neg;
		logic [63:0] mag;
	} num_t;

	// classified item between front and back
	typedef struct packed {
		num_t re;
		num_t im;
		logic sneg;
		logic [31:0] smag;
		logic zero;
	} job_t;

	typedef struct packed {
		logic neg;
		logic [31:0] rem;
		logic [63:0] num;
		logic [63:0] quo;
	} lane_t;

	typedef struct packed {
		lane_t re;
		lane_t im;
		logic sneg;
		logic [31:0] smag;
		logic zero;
	} div_t;

	typedef struct packed {
		logic [31:0] val;
		logic ovf;
	} lane_res_t;

	function automatic num_t split(input logic [63:0] s);
		num_t r;
		r.neg = s[63] && (s != 64'h8000_0000_0000_0000);
		r.mag = r.neg ? (64'd0 - s) : s;
		return r;
	endfunction

	// one restoring division step
	function automatic lane_t div_step(input lane_t l, input logic [31:0] smag);
		lane_t r;
		logic [32:0] t;
		logic ge;
		t = {l.rem, l.num[63]};
		ge = t >= {1'b0, smag};
		r.neg = l.neg;
		r.rem = ge ? 32'(t - {1'b0, smag}) : t[31:0];
		r.num = {l.num[62:0], 1'b0};
		r.quo = {l.quo[62:0], ge};
		return r;
	endfunction

	function automatic lane_res_t lane_finish(input lane_t l, input logic sneg);
		lane_res_t r;
		logic qneg;
		qneg = (l.neg != sneg) && (l.quo != 64'd0);
		if (qneg) begin
			r.ovf = l.quo > 64'h0000_0000_8000_0000;
			r.val = 32'(64'd0 - l.quo);
		end else begin
			r.ovf = l.quo > 64'h0000_0000_7FFF_FFFF;
			r.val = l.quo[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/cdiv_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cdiv_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [4:0]     radix,
	input  wire logic           op_valid,
	output logic                op_ready,
	input  wire cdiv_pkg::op_t  op,
	output logic                job_valid,
	input  wire logic           job_ready,
	output cdiv_pkg::job_t      job
);
	import cdiv_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [63:0] drr_s1, dii_s1, xrdr_s1, xidi_s1, xidr_s1, xrdi_s1;
	logic [63:0] mag_s2, re_s2, im_s2;
	job_t job_s3;
	logic [31:0] scale;

	assign adv = !v_s3 || job_ready;
	assign op_ready = adv;
	assign job_valid = v_s3;
	assign job = job_s3;
	assign scale = 32'(mag_s2 >> radix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= op_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drr_s1 <= op.divisor_real * op.divisor_real;
			dii_s1 <= op.divisor_imag * op.divisor_imag;
			xrdr_s1 <= op.dividend_real * op.divisor_real;
			xidi_s1 <= op.dividend_imag * op.divisor_imag;
			xidr_s1 <= op.dividend_imag * op.divisor_real;
			xrdi_s1 <= op.dividend_real * op.divisor_imag;
			mag_s2 <= 64'(drr_s1) + 64'(dii_s1);
			re_s2 <= 64'(xrdr_s1) + 64'(xidi_s1);
			im_s2 <= 64'(xidr_s1) - 64'(xrdi_s1);
			job_s3.re <= split(re_s2);
			job_s3.im <= split(im_s2);
			job_s3.sneg <= scale[31];
			job_s3.smag <= scale[31] ? (32'd0 - scale) : scale;
			job_s3.zero <= scale == 32'd0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/cdiv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cdiv_queue #(
	parameter int DEPTH = cdiv_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	input  wire cdiv_pkg::job_t  wr_data,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output cdiv_pkg::job_t       rd_data
);
	import cdiv_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

// File: rtl/cdiv_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cdiv_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	output logic                 job_ready,
	input  wire cdiv_pkg::job_t  job,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output cdiv_pkg::res_t       res
);
	import cdiv_pkg::*;

	logic adv;
	logic vld [DIV_STEPS+1];
	div_t stg [DIV_STEPS+1];
	logic res_valid_q;
	res_t res_q;
	lane_res_t fr, fi;

	assign adv = !res_valid_q || res_ready;
	assign job_ready = adv;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign vld[0] = job_valid;
	assign stg[0].re = '{neg: job.re.neg, rem: 32'd0, num: job.re.mag, quo: 64'd0};
	assign stg[0].im = '{neg: job.im.neg, rem: 32'd0, num: job.im.mag, quo: 64'd0};
	assign stg[0].sneg = job.sneg;
	assign stg[0].smag = job.smag;
	assign stg[0].zero = job.zero;

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (adv) begin
				vld[k] <= vld[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				stg[k].re <= div_step(stg[k-1].re, stg[k-1].smag);
				stg[k].im <= div_step(stg[k-1].im, stg[k-1].smag);
				stg[k].sneg <= stg[k-1].sneg;
				stg[k].smag <= stg[k-1].smag;
				stg[k].zero <= stg[k-1].zero;
			end
		end
	end

	assign fr = lane_finish(stg[DIV_STEPS].re, stg[DIV_STEPS].sneg);
	assign fi = lane_finish(stg[DIV_STEPS].im, stg[DIV_STEPS].sneg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (stg[DIV_STEPS].zero) begin
				res_q <= '{quotient_real: 32'sd0, quotient_imag: 32'sd0,
					divide_by_zero: 1'b1, quotient_overflow: 1'b0};
			end else begin
				res_q <= '{quotient_real: fr.val, quotient_imag: fi.val,
					divide_by_zero: 1'b0, quotient_overflow: fr.ovf || fi.ovf};
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/complex_fixed_point_divide.sv
// Path from op transaction to res valid: 3 multiply/classify stages, the queue,
// 64 one-bit divider stages and the output register. Throughput: one transaction
// per cycle unless res_ready stalls, set by the fully pipelined divider.
// Reset: arst_n clears all valid state and sets radix to 24; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module complex_fixed_point_divide #(
	parameter int QUEUE_DEPTH = cdiv_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire logic           op_valid,
	output logic                op_ready,
	input  wire cdiv_pkg::op_t  op,
	output logic                res_valid,
	input  wire logic           res_ready,
	output cdiv_pkg::res_t      res
);
	import cdiv_pkg::*;

	logic [4:0] radix_q;
	logic fj_valid, fj_ready, bj_valid, bj_ready;
	job_t fj, bj;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX) ? {27'd0, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
			radix_q <= pwdata[4:0];
		end
	end

	cdiv_front u_front (
		.clk(clk), .arst_n(arst_n), .radix(radix_q),
		.op_valid(op_valid), .op_ready(op_ready), .op(op),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	cdiv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	cdiv_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

endmodule
`default_nettype wire

// File: tb/sv/tb_complex_fixed_point_divide.sv
`timescale 1ns / 1ps
module tb_complex_fixed_point_divide;
	import cdiv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;
	localparam logic [2:0] ADDR_RADIX = 3'(4 * REG_RADIX);

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic op_valid, op_ready;
	op_t op;
	logic res_valid, res_ready;
	res_t res;

	op_t pending_ops[$];
	res_t expected_quotients[$];
	logic [4:0] radix_q;
	int errors;
	int idle_cycles;
	bit driver_calm;
	bit sink_calm;

	complex_fixed_point_divide dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.op_valid(op_valid), .op_ready(op_ready), .op(op),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic num_t to_sign_mag(input logic [63:0] s);
		num_t r;
		r.neg = s[63] && (s != 64'h8000_0000_0000_0000);
		r.mag = r.neg ? -s : s;
		return r;
	endfunction

	function automatic logic [31:0] lane_quotient(input logic [63:0] num, input logic sneg,
			input logic [63:0] smag, inout logic ovf);
		num_t n;
		logic [63:0] q;
		n = to_sign_mag(num);
		q = n.mag / smag;
		if (n.neg != sneg && q != 64'd0) begin
			if (q > 64'h8000_0000) ovf = 1'b1;
			return 32'(-q);
		end
		if (q > 64'h7FFF_FFFF) ovf = 1'b1;
		return q[31:0];
	endfunction

	function automatic res_t predict_quotient(input op_t x, input logic [4:0] rdx);
		res_t r;
		logic signed [63:0] xr, xi, dr, di;
		logic [63:0] mag, re_num, im_num, smag;
		logic [31:0] scale;
		logic sneg, ovf;
		xr = x.dividend_real;
		xi = x.dividend_imag;
		dr = x.divisor_real;
		di = x.divisor_imag;
		mag = dr * dr + di * di;
		scale = 32'(mag >> rdx);
		r = '0;
		if (scale == 32'd0) begin
			r.divide_by_zero = 1'b1;
			return r;
		end
		sneg = scale[31];
		smag = sneg ? 64'(32'(-scale)) : 64'(scale);
		if (sneg && smag == 64'd0) smag = 64'h8000_0000;
		re_num = xr * dr + xi * di;
		im_num = xi * dr - xr * di;
		ovf = 1'b0;
		r.quotient_real = lane_quotient(re_num, sneg, smag, ovf);
		r.quotient_imag = lane_quotient(im_num, sneg, smag, ovf);
		r.quotient_overflow = ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_RADIX) radix_q = data[4:0];
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 16)) - 8);
			3: return 32'($urandom) >>> $urandom_range(0, 31);
			4: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(input logic [31:0] a, b, c, d);
		op_t x;
		x.dividend_real = a;
		x.dividend_imag = b;
		x.divisor_real = c;
		x.divisor_imag = d;
		pending_ops.push_back(x);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || op_valid || expected_quotients.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid <= 1'b0;
			op <= '0;
		end else begin
			if (op_valid && op_ready) begin
				expected_quotients.push_back(predict_quotient(op, radix_q));
			end
			if (!op_valid || op_ready) begin
				if (pending_ops.size() != 0 && (driver_calm || $urandom_range(0, 99) >= 20)) begin
					op <= pending_ops.pop_front();
					op_valid <= 1'b1;
				end else begin
					op_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
			idle_cycles <= 0;
		end else begin
			res_ready <= sink_calm || $urandom_range(0, 99) >= 20;
			if ((op_valid && op_ready) || (res_valid && res_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (res_valid && res_ready) begin
				if (expected_quotients.size() == 0) begin
					report_mismatch("unexpected transaction", 32'd0, 32'd0);
				end else begin
					want = expected_quotients.pop_front();
					if (res.quotient_real !== want.quotient_real)
						report_mismatch("quotient_real", res.quotient_real, want.quotient_real);
					if (res.quotient_imag !== want.quotient_imag)
						report_mismatch("quotient_imag", res.quotient_imag, want.quotient_imag);
					if (res.divide_by_zero !== want.divide_by_zero)
						report_mismatch("divide_by_zero", 32'(res.divide_by_zero),
							32'(want.divide_by_zero));
					if (res.quotient_overflow !== want.quotient_overflow)
						report_mismatch("quotient_overflow", 32'(res.quotient_overflow),
							32'(want.quotient_overflow));
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[complex_fixed_point_divide] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [4:0] radix_plan[5];
		errors = 0;
		radix_q = RADIX_RESET;
		driver_calm = 1'b0;
		sink_calm = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset radix
		queue_op(32'h0100_0000, 32'h0, 32'h0100_0000, 32'h0);
		queue_op(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
		queue_op(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_op(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_op(32'h7FFF_FFFF, 32'h8000_0000, 32'h1000, 32'h0);
		queue_op(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1000);
		queue_op(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1);
		queue_op(32'h1234_5678, 32'hEDCB_A988, 32'h0800_0000, 32'hF800_0000);
		queue_op(32'h0, 32'h0, 32'h0B50_4F33, 32'h0B50_4F33);
		wait_drained();

		// radix extremes and the unused address
		apb_write(3'd4, 32'h5);
		apb_write(ADDR_RADIX, 32'd0);
		queue_op(32'h1, 32'h1, 32'h0000_B504, 32'h0000_B505);
		queue_op(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
		queue_op(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
		queue_op(32'h1, 32'h0, 32'h0001_0000, 32'h0);
		wait_drained();
		apb_write(ADDR_RADIX, 32'd31);
		queue_op(32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 32'h0);
		queue_op(32'h8000_0000, 32'hFFFF_FFFF, 32'hB504_F334, 32'h0);
		queue_op(32'h5, 32'h6, 32'h1, 32'h1);
		wait_drained();

		radix_plan = '{5'd0, 5'd31, 5'd30, 5'd24, 5'd12};
		foreach (radix_plan[p]) begin
			apb_write(ADDR_RADIX, {27'($urandom), radix_plan[p]});
			driver_calm = (p == 3);
			sink_calm = (p == 3);
			repeat (80) queue_op(pick_word(), pick_word(), pick_word(), pick_word());
			wait_drained();
		end

		if (errors == 0) begin
			$display("[complex_fixed_point_divide] OK");
		end else begin
			$display("[complex_fixed_point_divide] ERROR");
		end
		$finish;
	end

endmodule

// File: complex_fixed_point_divide.f
rtl/cdiv_pkg.sv
rtl/cdiv_front.sv
rtl/cdiv_queue.sv
rtl/cdiv_back.sv
rtl/complex_fixed_point_divide.sv
tb/sv/tb_complex_fixed_point_divide.sv
